### hdl/htru_pkg.sv
// shared types and constants for the huffman tree rle unpacker
package htru_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_W     = $clog2(WORD_BITS + 1);
  localparam int WALK_W    = 10;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_DECODE  = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [15:0] LEAF_FLAG    = 16'h8000;
  localparam logic [15:0] INTERNAL_MAX = 16'h0201;
  localparam logic [7:0]  NO_HIGH_BYTE = 8'hFF;
  localparam logic [7:0]  IDLE_MARK    = 8'hFF;
  localparam logic [7:0]  LIT_CONTROL  = 8'h80;
  localparam logic [7:0]  LIT_MASK     = 8'h7F;

  typedef struct packed {
    logic write;
    logic restart;
    logic load;
    logic step;
    logic feed_hi;
    logic feed_lo;
    logic flush;
  } htru_cmd_t;

  typedef struct packed {
    logic leaf;
    logic hi_skip;
    logic feed_stall;
    logic flush_stall;
  } htru_status_t;

endpackage

### hdl/htru_ram.sv
// generic simple dual port ram with registered read
module htru_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/htru_ctrl.sv
// sequencer for table writes, tree walk, byte feed and final flush
module htru_ctrl
  import htru_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [1:0]   opcode,
  input  htru_status_t status,
  output htru_cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    START,
    WALK,
    BYTE_HI,
    BYTE_LO,
    FINISH
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             accept;

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd         = '0;
    cmd.write   = accept && (opcode == OP_WRITE);
    cmd.restart = accept && (opcode == OP_RESTART);
    cmd.load    = accept && (opcode == OP_DECODE);
    cmd.step    = (state == WALK);
    cmd.feed_hi = (state == BYTE_HI);
    cmd.feed_lo = (state == BYTE_LO);
    cmd.flush   = (state == FINISH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        IDLE: begin
          cnt <= '0;
          if (accept && opcode == OP_DECODE) begin
            state <= START;
          end
        end
        // setup state so the node read reflects any table write just before
        START: state <= WALK;
        WALK: begin
          cnt <= cnt + 1'b1;
          if (status.leaf) begin
            state <= status.hi_skip ? BYTE_LO : BYTE_HI;
          end else if (cnt == CNT_W'(WORD_BITS - 1)) begin
            state <= FINISH;
          end
        end
        BYTE_HI: begin
          if (!status.feed_stall) begin
            state <= BYTE_LO;
          end
        end
        BYTE_LO: begin
          if (!status.feed_stall) begin
            state <= (cnt == CNT_W'(WORD_BITS)) ? FINISH : WALK;
          end
        end
        FINISH: begin
          if (!status.flush_stall) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.write, cmd.restart, cmd.load, cmd.step, cmd.feed_hi, cmd.feed_lo,
              cmd.flush}))
    else $error("more than one datapath command at once");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(WORD_BITS))
    else $error("bit counter past word length");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == WALK && cnt == CNT_W'(WORD_BITS - 1) && !status.leaf) |=> (state == FINISH))
    else $error("walk ran past the last bit");

endmodule

### hdl/htru_datapath.sv
// node table, tree walk registers, run-length stage and result registers
module htru_datapath
  import htru_pkg::*;
#(
  parameter int NODE_SLOTS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  htru_cmd_t            cmd,
  output htru_status_t         status,
  input  logic [9:0]           node_index,
  input  logic [31:0]          node_entry,
  input  logic [WORD_BITS-1:0] code_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic [7:0]           run_length,
  output logic                 last_of_item
);

  localparam int AW = $clog2(NODE_SLOTS);

  logic [WORD_BITS-1:0] shift;
  logic [WALK_W-1:0]    walk, walk_next;
  logic [15:0]          leaf;
  logic [7:0]           repeat_pending, literal_left;
  logic [7:0]           held_byte, held_run;
  logic                 held_valid;
  logic [31:0]          rdata;
  logic [15:0]          child;
  logic                 is_node;
  logic [7:0]           fbyte, new_run;
  logic                 emit, out_busy, feed_stall, feed_go, flush_go, ram_we;

  assign ram_we = cmd.write && ({1'b0, node_index} < 11'(NODE_SLOTS));

  htru_ram #(
    .WIDTH (32),
    .DEPTH (NODE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (node_index[AW-1:0]),
    .wdata (node_entry),
    .raddr (AW'(walk_next)),
    .rdata (rdata)
  );

  // msb of the shift register picks the child of the current node
  assign child   = shift[WORD_BITS-1] ? rdata[15:0] : rdata[31:16];
  assign is_node = (child < LEAF_FLAG) && (child <= INTERNAL_MAX);

  always_comb begin
    walk_next = walk;
    if (cmd.restart) begin
      walk_next = '0;
    end else if (cmd.step) begin
      walk_next = is_node ? child[WALK_W-1:0] : '0;
    end
  end

  assign fbyte      = cmd.feed_hi ? leaf[15:8] : leaf[7:0];
  assign emit       = (repeat_pending != IDLE_MARK) || (literal_left != IDLE_MARK);
  assign new_run    = (repeat_pending != IDLE_MARK) ? repeat_pending + 8'd1 : 8'd1;
  assign out_busy   = out_valid && !out_ready;
  // the newest result waits in the held register until the next one shows up
  assign feed_stall = emit && held_valid && out_busy;
  assign feed_go    = (cmd.feed_hi || cmd.feed_lo) && !feed_stall;
  assign flush_go   = cmd.flush && held_valid && !out_busy;

  assign status.leaf        = !is_node;
  assign status.hi_skip     = (child[15:8] == NO_HIGH_BYTE);
  assign status.feed_stall  = feed_stall;
  assign status.flush_stall = held_valid && out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      walk           <= '0;
      repeat_pending <= IDLE_MARK;
      literal_left   <= IDLE_MARK;
      held_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      walk <= walk_next;
      if (cmd.restart) begin
        repeat_pending <= IDLE_MARK;
        literal_left   <= IDLE_MARK;
      end else if (feed_go) begin
        if (repeat_pending != IDLE_MARK) begin
          repeat_pending <= IDLE_MARK;
        end else if (literal_left != IDLE_MARK) begin
          literal_left <= literal_left - 8'd1;
        end else if (fbyte < LIT_CONTROL) begin
          repeat_pending <= fbyte;
        end else begin
          literal_left <= fbyte & LIT_MASK;
        end
      end
      if (feed_go && emit) begin
        held_valid <= 1'b1;
      end else if (flush_go) begin
        held_valid <= 1'b0;
      end
      if ((feed_go && emit && held_valid) || flush_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shift <= code_word;
    end else if (cmd.step) begin
      shift <= {shift[WORD_BITS-2:0], 1'b0};
    end
    if (cmd.step && !is_node) begin
      leaf <= child;
    end
    if (feed_go && emit) begin
      held_byte <= fbyte;
      held_run  <= new_run;
    end
    if (feed_go && emit && held_valid) begin
      out_byte     <= held_byte;
      run_length   <= held_run;
      last_of_item <= 1'b0;
    end else if (flush_go) begin
      out_byte     <= held_byte;
      run_length   <= held_run;
      last_of_item <= 1'b1;
    end
  end

  a_walk_in_tree: assert property (@(posedge clk) disable iff (rst)
    walk <= WALK_W'(INTERNAL_MAX))
    else $error("walk position beyond internal node range");

  a_rle_exclusive: assert property (@(posedge clk) disable iff (rst)
    !((repeat_pending != IDLE_MARK) && (literal_left != IDLE_MARK)))
    else $error("repeat and literal run pending together");

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    flush_go |=> (!held_valid && out_valid && last_of_item))
    else $error("flush did not hand held result to output");

endmodule

### hdl/huffman_tree_rle_unpacker_core.sv
// top level of the huffman tree decoder with run-length expansion
//
// requests arrive on the s_ group, one per s_tvalid/s_tready handshake; the
// kind of request is s_tuser: node table write, decode of one code word, or
// stream restart. results leave on the m_ group as byte/run-length pairs, with
// m_tlast marking the final result caused by one decode request.
// a table write or restart is done on its handshake. a decode passes a setup state,
// then one code word bit per walk step through the node table read/select loop
// (up to 32 bits), one or two byte feeds per leaf for the run-length stage, and a
// final flush; each bit needs a single table read.
// requests are taken only between decodes; results sit in an output register
// and a one-deep held register, so the last result of a word can wait on
// m_tready while the next request is already taken.
// when m_tready stays low the walk pauses at the next result that finds both
// registers full; nothing is dropped.
// reset returns the walk to the root and clears pending runs and valid flags;
// table contents are undefined until written.
module huffman_tree_rle_unpacker_core
  import htru_pkg::*;
#(
  parameter int NODE_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // node_index[9:0], node_entry[41:10], code_word[73:42], zero
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_byte[7:0], run_length[15:8]
  output logic        m_tlast    // last_of_item
);

  htru_cmd_t    cmd;
  htru_status_t status;
  logic [7:0]   out_byte, run_length;

  htru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .opcode   (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  htru_datapath #(
    .NODE_SLOTS (NODE_SLOTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .node_index   (s_tdata[9:0]),
    .node_entry   (s_tdata[41:10]),
    .code_word    (s_tdata[73:42]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_byte     (out_byte),
    .run_length   (run_length),
    .last_of_item (m_tlast)
  );

  assign m_tdata = {run_length, out_byte};

endmodule
